// ===== sv/bmhq_pkg.sv =====
// Package for the binary max-heap queue: request and result word types,
// action and status codes, and the default capacity.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package bmhq_pkg;

	localparam int CAPACITY_DEF = 128;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic               action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] top_value;
		logic [7:0]         entry_count;
		logic               is_empty;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/binary_max_heap_queue.sv =====
// Binary max-heap priority queue over signed 32-bit values.
// Uses bmhq_pkg for the word types and codes.
//
// Usage: drive a request word (push a value, or pop the maximum) and raise
// start while busy is low; the word is taken at that clock edge and busy
// stays high until the result has been shown. The result word (status,
// current maximum or -1 when empty, entry count, empty flag) is on result
// for exactly one cycle with done high; the receiver cannot hold it off.
//
// Structure: the heap sits in a memory with registered read data that is given
// one useful access a cycle, and one signed comparator serves every
// comparison. A push climbs level by level: read the parent, then compare
// and write. A pop reads the last entry and takes it as the value to sink
// from the root, then per level reads the left child, reads the right child,
// then compares and writes. An overflow or underflow goes straight to the result.
// The next word may be started in the cycle after done.
//
// Reset clears the entry count and the sequencer; the memory is not
// cleared, as only entries below the count are ever used.
`default_nettype none

module binary_max_heap_queue import bmhq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	input  req_t request,
	output logic busy,
	output logic done,
	output res_t result
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = IW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_POP_RD, S_POP_LD,
		S_DN_RDL, S_DN_RDR, S_DN_CMP, S_RESP
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       pos_q;
	logic signed [31:0]  val_q;
	logic signed [31:0]  best_q;
	logic                left_q;
	logic signed [31:0]  top_q;
	logic [1:0]          status_q;

	logic signed [31:0]  mem [CAPACITY];
	logic signed [31:0]  rdata_q;

	logic [IW-1:0]       rd_addr;
	logic                we;
	logic [IW-1:0]       waddr;
	logic signed [31:0]  wdata;

	logic [IW-1:0]       parent;
	logic [XW-1:0]       left_idx;
	logic [XW-1:0]       right_idx;
	logic                left_ok;
	logic                right_ok;
	logic signed [31:0]  cmp_a;
	logic signed [31:0]  cmp_b;
	logic                a_lt_b;
	logic [CW+7:0]       cnt_wide;

	assign parent    = (pos_q - IW'(1)) >> 1;
	assign left_idx  = {pos_q, 1'b1};
	assign right_idx = left_idx + XW'(1);
	assign left_ok   = left_idx < XW'(cnt_q);
	assign right_ok  = right_idx < XW'(cnt_q);

	// The one comparator: parent against the climbing value, the sinking
	// value against the left child, then the best so far against the right.
	always_comb begin
		cmp_a = best_q;
		cmp_b = rdata_q;
		case (state_q)
			S_UP_CMP: begin
				cmp_a = rdata_q;
				cmp_b = val_q;
			end
			S_DN_RDR: begin
				cmp_a = val_q;
				cmp_b = rdata_q;
			end
			default: begin
				cmp_a = best_q;
				cmp_b = rdata_q;
			end
		endcase
	end
	assign a_lt_b = cmp_a < cmp_b;

	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = val_q;
		case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					rd_addr = parent;
				end
			end
			S_UP_CMP: begin
				we    = 1'b1;
				wdata = a_lt_b ? rdata_q : val_q;
			end
			S_POP_RD: rd_addr = cnt_q[IW-1:0];
			S_DN_RDL: begin
				if (left_ok) begin
					rd_addr = left_idx[IW-1:0];
				end else begin
					we = 1'b1;
				end
			end
			S_DN_RDR: begin
				if (right_ok) begin
					rd_addr = right_idx[IW-1:0];
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (right_ok && a_lt_b) begin
					wdata = rdata_q;
				end else if (left_q) begin
					wdata = best_q;
				end
			end
			default: begin
				rd_addr = '0;
				we      = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			status_q <= STAT_DONE;
			pos_q    <= '0;
			val_q    <= '0;
			best_q   <= '0;
			left_q   <= 1'b0;
			top_q    <= '0;
		end else begin
			if (we && waddr == '0) begin
				top_q <= wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= STAT_DONE;
						if (request.action == ACT_PUSH) begin
							if (cnt_q == CW'(CAPACITY)) begin
								status_q <= STAT_OVERFLOW;
								state_q  <= S_RESP;
							end else begin
								val_q   <= request.value;
								pos_q   <= cnt_q[IW-1:0];
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= STAT_UNDERFLOW;
								state_q  <= S_RESP;
							end else begin
								cnt_q   <= cnt_q - CW'(1);
								state_q <= S_POP_RD;
							end
						end
					end
				end
				S_UP_RD: state_q <= (pos_q == '0) ? S_RESP : S_UP_CMP;
				S_UP_CMP: begin
					if (a_lt_b) begin
						pos_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				// With the last entry gone nothing is left to sift.
				S_POP_RD: state_q <= (cnt_q == '0) ? S_RESP : S_POP_LD;
				S_POP_LD: begin
					val_q   <= rdata_q;
					pos_q   <= '0;
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: state_q <= left_ok ? S_DN_RDR : S_RESP;
				S_DN_RDR: begin
					left_q  <= a_lt_b;
					best_q  <= a_lt_b ? rdata_q : val_q;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (right_ok && a_lt_b) begin
						pos_q   <= right_idx[IW-1:0];
						state_q <= S_DN_RDL;
					end else if (left_q) begin
						pos_q   <= left_idx[IW-1:0];
						state_q <= S_DN_RDL;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cnt_wide = {8'b0, cnt_q};

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

	always_comb begin
		result.status      = status_q;
		result.top_value   = (cnt_q == '0) ? -32'sd1 : top_q;
		result.entry_count = cnt_wide[7:0];
		result.is_empty    = (cnt_q == '0);
	end

endmodule

`default_nettype wire

// ===== sv/bmhq_checker.sv =====
// Port-level checker for the binary max-heap queue, bound to the top level.
// Uses bmhq_pkg for the word types and status codes.
`default_nettype none

module bmhq_checker import bmhq_pkg::*; (
	input wire  clk,
	input wire  arst_n,
	input wire  start,
	input wire  busy,
	input wire  done,
	input res_t result
);

	// A word taken in must leave the block busy once it has been taken.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after a word was taken");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while no word was in progress");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_empty |->
			result.top_value == -32'sd1 && result.entry_count == 8'd0)
		else $error("empty queue reported with a maximum or a count");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STAT_UNDERFLOW |-> result.is_empty)
		else $error("underflow reported on a queue that holds entries");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (.*);

`default_nettype wire
